[rtl/core/efsa_pkg.sv]
// Shared constants and types for the earliest-free-server assignment block.
`default_nettype none
package efsa_pkg;

  localparam int MAX_SERVERS_DEF = 16;

  localparam int NUM_W   = 5;
  localparam int TIME_W  = 17;
  localparam int SVC_W   = 8;
  localparam int IDXO_W  = 4;
  localparam int FREE_W  = 24;
  localparam int TOTAL_W = 40;
  localparam int COUNT_W = 20;
  localparam int DUR_W   = 14;
  localparam int CFG_IDX_W = 2;
  localparam int NCMP_W  = 8;

  localparam logic [TIME_W-1:0] OPEN_RESET  = 17'd28800;
  localparam logic [TIME_W-1:0] CLOSE_RESET = 17'd61200;
  localparam logic [NUM_W-1:0]  NUM_RESET   = 5'd1;
  localparam logic [5:0]        SEC_PER_MIN = 6'd60;

  localparam logic [FREE_W-1:0]  FREE_MAX  = {FREE_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic {
    OP_ARRIVE  = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SERVERS = 2'd0,
    CFG_OPEN_TIME   = 2'd1,
    CFG_CLOSE_TIME  = 2'd2
  } cfg_idx_t;

endpackage
`default_nettype wire

[rtl/core/efsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module efsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/earliest_free_server_assign.sv]
// Top level: earliest-free-server assignment with a sequential minimum scan.
// A customer is scanned with one free-time RAM read per server in use (N) through a
// single comparator, then passes the drain, the start/wait arithmetic and the commit
// states; a stalled output holds the commit, and no new beat is taken before it.
// Restart and late-arrival beats skip the scan; every result is registered at the commit.
// Synchronous active-low reset: all servers free at 28800, totals zero.
`default_nettype none
module earliest_free_server_assign
  import efsa_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_operation,
  input  wire logic [TIME_W-1:0]    in_arrival_time,
  input  wire logic [SVC_W-1:0]     in_service_minutes,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_served,
  output logic [IDXO_W-1:0]         out_server_index,
  output logic [FREE_W-1:0]         out_start_time,
  output logic [FREE_W-1:0]         out_wait_seconds,
  output logic [TOTAL_W-1:0]        out_total_wait,
  output logic [COUNT_W-1:0]        out_served_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam logic [NCMP_W-1:0] MAX_CMP = NCMP_W'(MAX_SERVERS);
  localparam logic [IDX_W-1:0]  LAST_MAX = IDX_W'(MAX_SERVERS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_CALC  = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_W-1:0]  num_servers_r;
  logic [TIME_W-1:0] open_time_r, close_time_r;

  logic               op_r, late_r;
  logic [TIME_W-1:0]  arr_r;
  logic [DUR_W-1:0]   dur_r;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic [IDX_W-1:0]   cnt_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [FREE_W-1:0]  best_time_r;
  logic [FREE_W-1:0]  start_r, wait_r, newfree_r;
  logic [MAX_SERVERS-1:0] vld_r;
  logic [FREE_W-1:0]  base_r;
  logic [TOTAL_W-1:0] total_r;
  logic [COUNT_W-1:0] count_r;

  logic               out_valid_r, out_served_r;
  logic [IDXO_W-1:0]  out_idx_r;
  logic [FREE_W-1:0]  out_start_r, out_wait_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               accept, out_load, commit_serve, commit_restart;
  logic [FREE_W-1:0]  ram_q, cur_time;
  logic [FREE_W-1:0]  calc_start, calc_wait;
  logic [FREE_W:0]    free_sum;
  logic [TOTAL_W:0]   tot_sum;
  logic [TOTAL_W-1:0] tot_new;
  logic [COUNT_W-1:0] count_new;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_load  = (state_r == S_WRITE) && (!out_valid_r || !out_stall);
  assign commit_restart = out_load && (op_r == OP_RESTART);
  assign commit_serve   = out_load && (op_r == OP_ARRIVE) && !late_r;

  // Servers in use, clamped to 1..MAX_SERVERS, as a last index
  always_comb begin
    if (num_servers_r == '0) begin
      last_nxt = '0;
    end else if ({{(NCMP_W-NUM_W){1'b0}}, num_servers_r} > MAX_CMP) begin
      last_nxt = LAST_MAX;
    end else begin
      last_nxt = IDX_W'(num_servers_r - NUM_W'(1));
    end
  end

  efsa_ram #(
    .WIDTH (FREE_W),
    .DEPTH (MAX_SERVERS)
  ) u_free_ram (
    .clk     (clk),
    .wr_en   (commit_serve),
    .wr_addr (best_idx_r),
    .wr_data (newfree_r),
    .rd_en   (state_r == S_SCAN),
    .rd_addr (cnt_r),
    .rd_data (ram_q)
  );

  assign cur_time = vld_r[rd_idx_r] ? ram_q : base_r;

  always_comb begin
    if ({{(FREE_W-TIME_W){1'b0}}, arr_r} <= best_time_r) begin
      calc_start = best_time_r;
      calc_wait  = best_time_r - {{(FREE_W-TIME_W){1'b0}}, arr_r};
    end else begin
      calc_start = {{(FREE_W-TIME_W){1'b0}}, arr_r};
      calc_wait  = '0;
    end
    free_sum = {1'b0, calc_start} + {{(FREE_W+1-DUR_W){1'b0}}, dur_r};
  end

  assign tot_sum   = {1'b0, total_r} + {{(TOTAL_W+1-FREE_W){1'b0}}, wait_r};
  assign tot_new   = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
  assign count_new = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_RESTART ||
              {{(FREE_W-TIME_W){1'b0}}, in_arrival_time} >
              {{(FREE_W-TIME_W){1'b0}}, close_time_r}) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN:  if (cnt_r == last_r) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_CALC;
      S_CALC:  state_nxt = S_WRITE;
      S_WRITE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      num_servers_r <= NUM_RESET;
      open_time_r   <= OPEN_RESET;
      close_time_r  <= CLOSE_RESET;
      vld_r         <= '0;
      base_r        <= {{(FREE_W-TIME_W){1'b0}}, OPEN_RESET};
      total_r       <= '0;
      count_r       <= '0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_NUM_SERVERS: num_servers_r <= cfg_data[NUM_W-1:0];
          CFG_OPEN_TIME:   open_time_r   <= cfg_data;
          CFG_CLOSE_TIME:  close_time_r  <= cfg_data;
          default: ;
        endcase
      end

      rd_vld_r <= (state_r == S_SCAN);

      if (commit_restart) begin
        vld_r   <= '0;
        base_r  <= {{(FREE_W-TIME_W){1'b0}}, open_time_r};
        total_r <= '0;
        count_r <= '0;
      end else if (commit_serve) begin
        vld_r[best_idx_r] <= 1'b1;
        total_r <= tot_new;
        count_r <= count_new;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      late_r <= ({{(FREE_W-TIME_W){1'b0}}, in_arrival_time} >
                 {{(FREE_W-TIME_W){1'b0}}, close_time_r});
      arr_r  <= in_arrival_time;
      dur_r  <= DUR_W'(in_service_minutes) * DUR_W'(SEC_PER_MIN);
      last_r <= last_nxt;
      cnt_r  <= '0;
    end else if (state_r == S_SCAN && cnt_r != last_r) begin
      cnt_r <= cnt_r + IDX_W'(1);
    end

    if (state_r == S_SCAN) begin
      rd_idx_r <= cnt_r;
    end

    if (rd_vld_r && (rd_idx_r == '0 || cur_time < best_time_r)) begin
      best_time_r <= cur_time;
      best_idx_r  <= rd_idx_r;
    end

    if (state_r == S_CALC) begin
      start_r   <= calc_start;
      wait_r    <= calc_wait;
      newfree_r <= free_sum[FREE_W] ? FREE_MAX : free_sum[FREE_W-1:0];
    end

    if (out_load) begin
      if (op_r == OP_RESTART) begin
        out_served_r <= 1'b0;
        out_idx_r    <= '0;
        out_start_r  <= '0;
        out_wait_r   <= '0;
        out_total_r  <= '0;
        out_count_r  <= '0;
      end else if (late_r) begin
        out_served_r <= 1'b0;
        out_idx_r    <= '0;
        out_start_r  <= '0;
        out_wait_r   <= '0;
        out_total_r  <= total_r;
        out_count_r  <= count_r;
      end else begin
        out_served_r <= 1'b1;
        out_idx_r    <= IDXO_W'({{IDXO_W{1'b0}}, best_idx_r});
        out_start_r  <= start_r;
        out_wait_r   <= wait_r;
        out_total_r  <= tot_new;
        out_count_r  <= count_new;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_served       = out_served_r;
  assign out_server_index = out_idx_r;
  assign out_start_time   = out_start_r;
  assign out_wait_seconds = out_wait_r;
  assign out_total_wait   = out_total_r;
  assign out_served_count = out_count_r;

endmodule
`default_nettype wire

[rtl/core/efsa_checker.sv]
// Port-level checker for the earliest-free-server assignment block, with its bind.
`default_nettype none
module efsa_checker
  import efsa_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 out_served,
  input wire logic [IDXO_W-1:0]    out_server_index,
  input wire logic [FREE_W-1:0]    out_start_time,
  input wire logic [FREE_W-1:0]    out_wait_seconds,
  input wire logic [TOTAL_W-1:0]   out_total_wait,
  input wire logic [COUNT_W-1:0]   out_served_count
);

  // An accepted beat keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken on the cycle after an accepted beat");

  // Unserved results carry no assignment
  a_unserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_served) |->
      (out_server_index == '0 && out_start_time == '0 && out_wait_seconds == '0))
    else $error("unserved result carries an assignment");

  // Wait never exceeds the start second
  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_served) |-> (out_wait_seconds <= out_start_time))
    else $error("wait larger than start time");

  // Served results always count at least one customer
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_served) |-> (out_served_count != '0))
    else $error("served result with zero count");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_served) && $stable(out_start_time) &&
       $stable(out_total_wait) && $stable(out_served_count)))
    else $error("stalled result beat changed");

endmodule

bind earliest_free_server_assign efsa_checker u_efsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_served       (out_served),
  .out_server_index (out_server_index),
  .out_start_time   (out_start_time),
  .out_wait_seconds (out_wait_seconds),
  .out_total_wait   (out_total_wait),
  .out_served_count (out_served_count)
);
`default_nettype wire

[verif/tb_earliest_free_server_assign.sv]
// Self-checking testbench for earliest_free_server_assign: directed table and random queues.
module tb_earliest_free_server_assign;
  timeunit 1ns;
  timeprecision 1ps;
  import efsa_pkg::*;

  localparam int ARR_MAX = (1 << TIME_W) - 1;

  typedef struct packed {
    logic                served;
    logic [IDXO_W-1:0]   index;
    logic [FREE_W-1:0]   start;
    logic [FREE_W-1:0]   waited;
    logic [TOTAL_W-1:0]  total;
    logic [COUNT_W-1:0]  count;
  } assignment_t;

  typedef enum {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    op_t          op;
    int           arr;
    int           svc;
    cfg_idx_t     sel;
    int           data;
    bit           typed;
    assignment_t  res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic [TIME_W-1:0]    in_arrival_time;
  logic [SVC_W-1:0]     in_service_minutes;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_served;
  logic [IDXO_W-1:0]    out_server_index;
  logic [FREE_W-1:0]    out_start_time;
  logic [FREE_W-1:0]    out_wait_seconds;
  logic [TOTAL_W-1:0]   out_total_wait;
  logic [COUNT_W-1:0]   out_served_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0]    cfg_data;

  earliest_free_server_assign u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_arrival_time    (in_arrival_time),
    .in_service_minutes (in_service_minutes),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_served         (out_served),
    .out_server_index   (out_server_index),
    .out_start_time     (out_start_time),
    .out_wait_seconds   (out_wait_seconds),
    .out_total_wait     (out_total_wait),
    .out_served_count   (out_served_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's state and registers
  logic [FREE_W-1:0]  free_at [MAX_SERVERS_DEF];
  logic [TOTAL_W-1:0] wait_sum;
  logic [COUNT_W-1:0] served_num;
  logic [NUM_W-1:0]   num_cfg;
  logic [TIME_W-1:0]  open_cfg;
  logic [TIME_W-1:0]  close_cfg;

  assignment_t pending_assignments [$];
  dir_row_t    directed_tbl [$];

  int mismatches;
  int burst_left;
  int beats_sent, customers_served, late_drops, restarts, results_seen;

  function automatic assignment_t next_assignment(op_t op, logic [TIME_W-1:0] arr,
                                                  logic [SVC_W-1:0] svc);
    assignment_t        r;
    int                 n;
    int                 best;
    logic [FREE_W-1:0]  dur;
    logic [FREE_W-1:0]  base;
    logic [FREE_W:0]    sum;
    logic [TOTAL_W:0]   tsum;
    r = '0;
    r.total = wait_sum;
    r.count = served_num;
    if (op == OP_RESTART) begin
      for (int i = 0; i < MAX_SERVERS_DEF; i++) free_at[i] = FREE_W'(open_cfg);
      wait_sum = '0;
      served_num = '0;
      r.total = '0;
      r.count = '0;
      return r;
    end
    if (arr > close_cfg) return r;
    n = (num_cfg == 0) ? 1 : (int'(num_cfg) > MAX_SERVERS_DEF ? MAX_SERVERS_DEF : int'(num_cfg));
    best = 0;
    for (int j = 1; j < n; j++)
      if (free_at[j] < free_at[best]) best = j;
    dur = FREE_W'(svc) * FREE_W'(SEC_PER_MIN);
    if (FREE_W'(arr) <= free_at[best]) begin
      base = free_at[best];
      r.waited = base - FREE_W'(arr);
      tsum = {1'b0, wait_sum} + (TOTAL_W+1)'(r.waited);
      wait_sum = (tsum > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX : tsum[TOTAL_W-1:0];
    end else begin
      base = FREE_W'(arr);
      r.waited = '0;
    end
    r.start = base;
    sum = {1'b0, base} + {1'b0, dur};
    free_at[best] = sum[FREE_W] ? FREE_MAX : sum[FREE_W-1:0];
    if (served_num != COUNT_MAX) served_num = served_num + 1'b1;
    r.served = 1'b1;
    r.index = IDXO_W'(best);
    r.total = wait_sum;
    r.count = served_num;
    return r;
  endfunction

  function automatic assignment_t res(bit served, int idx, int start, int waited,
                                      longint total, int count);
    assignment_t r;
    r.served = served;
    r.index  = IDXO_W'(idx);
    r.start  = FREE_W'(start);
    r.waited = FREE_W'(waited);
    r.total  = TOTAL_W'(total);
    r.count  = COUNT_W'(count);
    return r;
  endfunction

  function automatic dir_row_t beat_row(op_t op, int arr, int svc, bit typed = 1'b0,
                                        assignment_t r = '0);
    dir_row_t row;
    row.kind = ROW_BEAT;
    row.op = op;
    row.arr = arr;
    row.svc = svc;
    row.sel = CFG_NUM_SERVERS;
    row.data = 0;
    row.typed = typed;
    row.res = r;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_t sel, int data);
    dir_row_t row;
    row = beat_row(OP_ARRIVE, 0, 0);
    row.kind = ROW_CFG;
    row.sel = sel;
    row.data = data;
    return row;
  endfunction

  task automatic report(string what, assignment_t want, assignment_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: want served=%0b idx=%0d start=%0d wait=%0d total=%0d count=%0d",
               $realtime, what, want.served, want.index, want.start, want.waited,
               want.total, want.count);
      $display("%0t %s:  got served=%0b idx=%0d start=%0d wait=%0d total=%0d count=%0d",
               $realtime, what, got.served, got.index, got.start, got.waited,
               got.total, got.count);
    end
  endtask

  always @(posedge clk) begin : result_check
    assignment_t got;
    assignment_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_served, out_server_index, out_start_time, out_wait_seconds,
             out_total_wait, out_served_count};
      results_seen++;
      if (pending_assignments.size() == 0) begin
        report("unexpected beat", '0, got);
      end else begin
        want = pending_assignments.pop_front();
        if (got.served !== want.served || got.index !== want.index ||
            got.start !== want.start || got.waited !== want.waited ||
            got.total !== want.total || got.count !== want.count)
          report("mismatch", want, got);
      end
    end
  end

  // receiver back-pressure: free flow, light, heavy and periodic stretches
  initial begin : stall_pattern
    int mode;
    int len;
    int period;
    int on;
    int cyc;
    out_stall = 1'b0;
    cyc = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 200);
      period = $urandom_range(2, 16);
      on = $urandom_range(1, period - 1);
      repeat (len) begin
        @(negedge clk);
        cyc++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((cyc % period) < on);
        endcase
      end
    end
  end

  task automatic send_beat(op_t op, logic [TIME_W-1:0] arr, logic [SVC_W-1:0] svc,
                           bit typed = 1'b0, assignment_t typed_res = '0);
    assignment_t want;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_arrival_time <= arr;
    in_service_minutes <= svc;
    do @(posedge clk); while (in_stall);
    want = next_assignment(op, arr, svc);
    if (typed) want = typed_res;
    pending_assignments.push_back(want);
    beats_sent++;
    if (op == OP_RESTART) restarts++;
    else if (!want.served) late_drops++;
    else customers_served++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain_results(int settle);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_assignments.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t sel, logic [TIME_W-1:0] data);
    drain_results(4);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      CFG_NUM_SERVERS: num_cfg = data[NUM_W-1:0];
      CFG_OPEN_TIME:   open_cfg = data;
      CFG_CLOSE_TIME:  close_cfg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int cursor;
    int step_max;
    int roll;
    int open_v;
    int close_v;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_ARRIVE;
    in_arrival_time = '0;
    in_service_minutes = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NUM_SERVERS;
    cfg_data = '0;
    num_cfg = NUM_RESET;
    open_cfg = OPEN_RESET;
    close_cfg = CLOSE_RESET;
    for (int i = 0; i < MAX_SERVERS_DEF; i++) free_at[i] = FREE_W'(OPEN_RESET);
    wait_sum = '0;
    served_num = '0;
    burst_left = 0;

    // reset values: one server, open 28800, close 61200
    directed_tbl.push_back(beat_row(OP_ARRIVE, 0, 0, 1, res(1, 0, 28800, 28800, 28800, 1)));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 86399, 255, 1, res(0, 0, 0, 0, 28800, 1)));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 61200, 255, 1, res(1, 0, 61200, 0, 28800, 2)));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 61200, 1, 1, res(1, 0, 76500, 15300, 44100, 3)));
    directed_tbl.push_back(beat_row(OP_RESTART, ARR_MAX, 255, 1, res(0, 0, 0, 0, 0, 0)));
    directed_tbl.push_back(beat_row(OP_ARRIVE, ARR_MAX, 0, 1, res(0, 0, 0, 0, 0, 0)));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 28800, 255, 1, res(1, 0, 28800, 0, 0, 1)));
    directed_tbl.push_back(cfg_row(CFG_NUM_SERVERS, 4));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 30000, 10));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 30000, 10));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 30000, 10));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 30001, 0));
    directed_tbl.push_back(cfg_row(CFG_NUM_SERVERS, 0));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 30002, 5));
    directed_tbl.push_back(cfg_row(CFG_NUM_SERVERS, 31));
    directed_tbl.push_back(beat_row(OP_RESTART, 0, 0, 1, res(0, 0, 0, 0, 0, 0)));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 28800, 1));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 28800, 1));
    directed_tbl.push_back(cfg_row(CFG_OPEN_TIME, ARR_MAX));
    directed_tbl.push_back(cfg_row(CFG_CLOSE_TIME, ARR_MAX));
    directed_tbl.push_back(beat_row(OP_RESTART, 0, 0, 1, res(0, 0, 0, 0, 0, 0)));
    directed_tbl.push_back(beat_row(OP_ARRIVE, ARR_MAX, 255, 1,
                                    res(1, 0, ARR_MAX, 0, 0, 1)));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 0, 255, 1,
                                    res(1, 1, ARR_MAX, ARR_MAX, ARR_MAX, 2)));
    directed_tbl.push_back(cfg_row(CFG_OPEN_TIME, 0));
    directed_tbl.push_back(cfg_row(CFG_CLOSE_TIME, 0));
    directed_tbl.push_back(beat_row(OP_RESTART, 0, 0, 1, res(0, 0, 0, 0, 0, 0)));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 0, 0, 1, res(1, 0, 0, 0, 0, 1)));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 1, 0, 1, res(0, 0, 0, 0, 0, 1)));
    directed_tbl.push_back(beat_row(OP_ARRIVE, 0, 0, 1, res(1, 0, 0, 0, 0, 2)));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].kind == ROW_CFG)
        write_reg(directed_tbl[i].sel, TIME_W'(directed_tbl[i].data));
      else
        send_beat(directed_tbl[i].op, TIME_W'(directed_tbl[i].arr),
                  SVC_W'(directed_tbl[i].svc), directed_tbl[i].typed, directed_tbl[i].res);
    end

    // random days: mostly sorted arrivals, some noise, late and restart beats
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 7))
        0:       write_reg(CFG_NUM_SERVERS, '0);
        1:       write_reg(CFG_NUM_SERVERS, TIME_W'($urandom_range(17, 31)));
        2:       write_reg(CFG_NUM_SERVERS, TIME_W'(MAX_SERVERS_DEF));
        default: write_reg(CFG_NUM_SERVERS, TIME_W'($urandom_range(1, 16)));
      endcase
      case ($urandom_range(0, 7))
        0:       open_v = 0;
        1:       open_v = ARR_MAX;
        default: open_v = $urandom_range(20000, 40000);
      endcase
      case ($urandom_range(0, 7))
        0:       close_v = open_v;
        1:       close_v = ARR_MAX;
        2:       close_v = $urandom_range(0, ARR_MAX);
        default: close_v = open_v + $urandom_range(3600, 36000);
      endcase
      if (close_v > ARR_MAX) close_v = ARR_MAX;
      write_reg(CFG_OPEN_TIME, TIME_W'(open_v));
      write_reg(CFG_CLOSE_TIME, TIME_W'(close_v));
      step_max = $urandom_range(0, 900);
      cursor = open_v - $urandom_range(0, 600);
      if (cursor < 0) cursor = 0;
      send_beat(OP_RESTART, TIME_W'($urandom_range(0, ARR_MAX)), SVC_W'($urandom_range(0, 255)));
      for (int k = 0; k < 112; k++) begin
        roll = $urandom_range(0, 99);
        if (k == 56) drain_results(1);
        if (roll < 3 || (cursor > close_v && roll < 50)) begin
          send_beat(OP_RESTART, TIME_W'($urandom_range(0, ARR_MAX)),
                    SVC_W'($urandom_range(0, 255)));
          cursor = open_v - $urandom_range(0, 600);
          if (cursor < 0) cursor = 0;
        end else if (roll < 12) begin
          send_beat(OP_ARRIVE, TIME_W'($urandom_range(0, ARR_MAX)),
                    SVC_W'($urandom_range(0, 255)));
        end else begin
          cursor += $urandom_range(0, step_max);
          if (cursor > ARR_MAX) cursor = ARR_MAX;
          send_beat(OP_ARRIVE, TIME_W'(cursor),
                    SVC_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255)));
        end
      end
    end

    drain_results(30);
    $display("%0d beats sent, %0d results checked: %0d served, %0d dropped late, %0d restarts",
             beats_sent, results_seen, customers_served, late_drops, restarts);
    $display("server counts 0..31, open/close 0..%0d, bursts against random receiver stalls",
             ARR_MAX);
    if (mismatches == 0 && pending_assignments.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_assignments.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
